/* src/dual_converter_pwm_regulator_assert.svh */
// Assertion macros for the regulator checker
`ifndef DUAL_CONVERTER_PWM_REGULATOR_ASSERT_SVH
`define DUAL_CONVERTER_PWM_REGULATOR_ASSERT_SVH
`define DCPR_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define DCPR_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

/* src/dcpr_pkg.sv */
// ----------------------------------------------------------------------------
// dcpr_pkg
// Shared types and constants of the dual converter regulator.
// ----------------------------------------------------------------------------
package dcpr_pkg;
    localparam int unsigned BOOST_LIMIT_MV = 20000;
    localparam int unsigned BUCK_FLOOR_MV  = 1500;
    localparam logic [20:0] VREF_PRODUCT   = 21'd1125300;
    localparam logic [20:0] SUPPLY_RESET   = 21'd5000;
    localparam logic [19:0] LEVEL_MAX      = 20'hFFFFF;
    localparam logic [9:0]  ADC_FULL       = 10'd1023;

    localparam logic [2:0] REG_BOOST_TARGET = 3'd0;
    localparam logic [2:0] REG_BOOST_MAX    = 3'd1;
    localparam logic [2:0] REG_BOOST_TOP    = 3'd2;
    localparam logic [2:0] REG_BOOST_BOT    = 3'd3;
    localparam logic [2:0] REG_BUCK_TARGET  = 3'd4;
    localparam logic [2:0] REG_BUCK_TOP     = 3'd5;
    localparam logic [2:0] REG_BUCK_BOT     = 3'd6;
    localparam logic [2:0] REG_INTERVAL     = 3'd7;

    typedef struct packed {
        logic [9:0] boost_sample;
        logic [9:0] buck_sample;
        logic [9:0] reference_sample;
        logic       power_on;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  boost_duty;
        logic [7:0]  buck_duty;
        logic [19:0] boost_measured_mv;
        logic [19:0] buck_measured_mv;
        logic [20:0] supply_mv;
        logic        boost_shutdown;
        logic        buck_shutdown;
    } out_item_t;

    typedef struct packed {
        logic [15:0] boost_target_mv;
        logic [7:0]  boost_duty_max;
        logic [19:0] boost_r_top;
        logic [19:0] boost_r_bottom;
        logic [15:0] buck_target_mv;
        logic [19:0] buck_r_top;
        logic [19:0] buck_r_bottom;
        logic [15:0] supply_refresh_interval;
    } cfg_t;
endpackage

/* src/dcpr_serial_mul.sv */
// ----------------------------------------------------------------------------
// dcpr_serial_mul
// Shift-add multiplier, one multiplier bit per cycle (32 x 32 -> 64).
// ----------------------------------------------------------------------------
module dcpr_serial_mul (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic        done,
    output logic [63:0] product
);
    logic [63:0] acc_reg;
    logic [63:0] mcand_reg;
    logic [31:0] mplier_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            mcand_reg  <= {32'd0, a};
            mplier_reg <= b;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_reg <= acc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[62:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[31:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

/* src/dcpr_serial_div.sv */
// ----------------------------------------------------------------------------
// dcpr_serial_div
// Restoring divider, one quotient bit per cycle (64 / 32).
// ----------------------------------------------------------------------------
module dcpr_serial_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] num,
    input  logic [31:0] den,
    output logic        done,
    output logic [63:0] quot
);
    logic [63:0] q_reg;
    logic [32:0] rem_reg;
    logic [31:0] den_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg[31:0], q_reg[63]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_reg <= trial - {1'b0, den_reg};
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule

/* src/dual_converter_pwm_regulator.sv */
// ----------------------------------------------------------------------------
// dual_converter_pwm_regulator
// Bang-bang incremental PWM regulator for one boost and one buck converter.
// ----------------------------------------------------------------------------
// Usage:
//   in (in_valid/in_stall/in_data): one item per control tick, carrying the
//   boost, buck and reference samples and the power-line state.
//   out (out_valid/out_stall/out_data): one result item per input item with
//   both duties, both measured levels, the supply estimate and shutdown flags.
//   APB port: eight registers at 4*i, written with psel/penable/pwrite.
// Throughput: one item at a time; the pace is set by one bit-serial divider,
//   used in turn for the supply refresh and both conversions, and one
//   bit-serial multiplier shared by both conversions; a converter that is
//   shut down skips its multiply and divide steps.
// Reset: registers take their default values, supply estimate 5000 mV,
//   boost duty 0, buck duty 255, levels 0.
// Stall: a result waits in the output register; in_stall stays high until
//   it is taken, so no item is lost.
module dual_converter_pwm_regulator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dcpr_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output dcpr_pkg::out_item_t out_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    typedef enum logic [3:0] {
        S_IDLE, S_REF_DIV, S_BST_MUL, S_BST_DIV, S_BST_MUL2, S_BST_DIV2,
        S_BCK_MUL, S_BCK_DIV, S_BCK_MUL2, S_BCK_DIV2, S_FINISH, S_OUT
    } state_t;

    state_t              state_reg;
    dcpr_pkg::cfg_t      cfg_reg;
    dcpr_pkg::in_item_t  item_reg;
    dcpr_pkg::out_item_t out_reg;
    logic [15:0] tick_reg;
    logic [20:0] supply_reg;
    logic [7:0]  boost_duty_reg;
    logic [7:0]  buck_duty_reg;
    logic [19:0] boost_level_reg;
    logic [19:0] buck_level_reg;
    logic [63:0] val_reg;
    logic        wait_reg;

    logic        mul_start, div_start, mul_done, div_done;
    logic [31:0] mul_a, mul_b, div_den;
    logic [63:0] mul_p, div_num, div_q;
    logic [15:0] tick_inc;
    logic        boost_off, buck_off;
    logic [20:0] boost_sum, buck_sum;
    logic [19:0] sat_q;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    dcpr_serial_mul u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .product(mul_p)
    );

    dcpr_serial_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quot(div_q)
    );

    assign tick_inc  = tick_reg + 16'd1;
    assign boost_off = (cfg_reg.boost_target_mv > 16'(dcpr_pkg::BOOST_LIMIT_MV))
                       || !item_reg.power_on;
    assign buck_off  = (cfg_reg.buck_target_mv < 16'(dcpr_pkg::BUCK_FLOOR_MV))
                       || !item_reg.power_on;
    assign boost_sum = {1'b0, cfg_reg.boost_r_top} + {1'b0, cfg_reg.boost_r_bottom};
    assign buck_sum  = {1'b0, cfg_reg.buck_r_top} + {1'b0, cfg_reg.buck_r_bottom};
    assign sat_q     = (div_q > {44'd0, dcpr_pkg::LEVEL_MAX}) ? dcpr_pkg::LEVEL_MAX
                       : div_q[19:0];

    always_comb
    begin
        mul_start = 1'b0;
        div_start = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        div_num   = val_reg;
        div_den   = {22'd0, dcpr_pkg::ADC_FULL};
        if (!wait_reg)
        begin
            case (state_reg)
                S_REF_DIV:
                begin
                    div_start = 1'b1;
                    div_num   = {43'd0, dcpr_pkg::VREF_PRODUCT};
                    div_den   = {22'd0, item_reg.reference_sample};
                end
                S_BST_MUL:
                begin
                    mul_start = !boost_off;
                    mul_a     = {22'd0, item_reg.boost_sample};
                    mul_b     = {11'd0, supply_reg};
                end
                S_BCK_MUL:
                begin
                    mul_start = !buck_off;
                    mul_a     = {22'd0, item_reg.buck_sample};
                    mul_b     = {11'd0, supply_reg};
                end
                S_BST_DIV, S_BCK_DIV:
                begin
                    div_start = 1'b1;
                end
                S_BST_MUL2:
                begin
                    mul_start = 1'b1;
                    mul_a     = val_reg[31:0];
                    mul_b     = {11'd0, boost_sum};
                end
                S_BCK_MUL2:
                begin
                    mul_start = 1'b1;
                    mul_a     = val_reg[31:0];
                    mul_b     = {11'd0, buck_sum};
                end
                S_BST_DIV2:
                begin
                    div_start = 1'b1;
                    div_den   = {12'd0, cfg_reg.boost_r_bottom};
                end
                S_BCK_DIV2:
                begin
                    div_start = 1'b1;
                    div_den   = {12'd0, cfg_reg.buck_r_bottom};
                end
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            wait_reg        <= 1'b0;
            tick_reg        <= '0;
            supply_reg      <= dcpr_pkg::SUPPLY_RESET;
            boost_duty_reg  <= '0;
            buck_duty_reg   <= 8'hFF;
            boost_level_reg <= '0;
            buck_level_reg  <= '0;
            cfg_reg.boost_target_mv         <= 16'd10000;
            cfg_reg.boost_duty_max          <= 8'd200;
            cfg_reg.boost_r_top             <= 20'd10000;
            cfg_reg.boost_r_bottom          <= 20'd3300;
            cfg_reg.buck_target_mv          <= 16'd2500;
            cfg_reg.buck_r_top              <= '0;
            cfg_reg.buck_r_bottom           <= '0;
            cfg_reg.supply_refresh_interval <= 16'd10000;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (cfg_idx)
                    dcpr_pkg::REG_BOOST_TARGET: cfg_reg.boost_target_mv <= pwdata[15:0];
                    dcpr_pkg::REG_BOOST_MAX:    cfg_reg.boost_duty_max <= pwdata[7:0];
                    dcpr_pkg::REG_BOOST_TOP:    cfg_reg.boost_r_top <= pwdata[19:0];
                    dcpr_pkg::REG_BOOST_BOT:    cfg_reg.boost_r_bottom <= pwdata[19:0];
                    dcpr_pkg::REG_BUCK_TARGET:  cfg_reg.buck_target_mv <= pwdata[15:0];
                    dcpr_pkg::REG_BUCK_TOP:     cfg_reg.buck_r_top <= pwdata[19:0];
                    dcpr_pkg::REG_BUCK_BOT:     cfg_reg.buck_r_bottom <= pwdata[19:0];
                    dcpr_pkg::REG_INTERVAL:
                        cfg_reg.supply_refresh_interval <= pwdata[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (mul_start || div_start)
            begin
                wait_reg <= 1'b1;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        if (tick_inc >= cfg_reg.supply_refresh_interval)
                        begin
                            tick_reg  <= '0;
                            state_reg <= (in_data.reference_sample != 10'd0)
                                         ? S_REF_DIV : S_BST_MUL;
                        end
                        else
                        begin
                            tick_reg  <= tick_inc;
                            state_reg <= S_BST_MUL;
                        end
                    end
                end
                S_REF_DIV:
                begin
                    if (div_done)
                    begin
                        supply_reg <= div_q[20:0];
                        wait_reg   <= 1'b0;
                        state_reg  <= S_BST_MUL;
                    end
                end
                S_BST_MUL, S_BST_MUL2, S_BCK_MUL, S_BCK_MUL2:
                begin
                    if (state_reg == S_BST_MUL && !wait_reg && boost_off)
                    begin
                        boost_duty_reg <= '0;
                        state_reg      <= S_BCK_MUL;
                    end
                    else if (mul_done)
                    begin
                        val_reg   <= mul_p;
                        wait_reg  <= 1'b0;
                        state_reg <= state_t'(state_reg + 4'd1);
                    end
                end
                S_BST_DIV, S_BST_DIV2:
                begin
                    if (div_done)
                    begin
                        wait_reg <= 1'b0;
                        if (state_reg == S_BST_DIV && cfg_reg.boost_r_top != 20'd0
                            && cfg_reg.boost_r_bottom != 20'd0)
                        begin
                            val_reg   <= div_q;
                            state_reg <= S_BST_MUL2;
                        end
                        else
                        begin
                            boost_level_reg <= sat_q;
                            if ({4'd0, cfg_reg.boost_target_mv} > sat_q)
                            begin
                                boost_duty_reg <= (boost_duty_reg >= cfg_reg.boost_duty_max)
                                    ? cfg_reg.boost_duty_max : boost_duty_reg + 8'd1;
                            end
                            else if ({4'd0, cfg_reg.boost_target_mv} < sat_q)
                            begin
                                boost_duty_reg <= (boost_duty_reg == 8'd0) ? 8'd0
                                    : ((boost_duty_reg - 8'd1 > cfg_reg.boost_duty_max)
                                       ? cfg_reg.boost_duty_max : boost_duty_reg - 8'd1);
                            end
                            state_reg <= S_BCK_MUL;
                        end
                    end
                end
                S_BCK_DIV, S_BCK_DIV2:
                begin
                    if (div_done)
                    begin
                        wait_reg <= 1'b0;
                        if (state_reg == S_BCK_DIV && cfg_reg.buck_r_top != 20'd0
                            && cfg_reg.buck_r_bottom != 20'd0)
                        begin
                            val_reg   <= div_q;
                            state_reg <= S_BCK_MUL2;
                        end
                        else
                        begin
                            buck_level_reg <= sat_q;
                            if ({4'd0, cfg_reg.buck_target_mv} > sat_q)
                            begin
                                if (buck_duty_reg != 8'd0)
                                begin
                                    buck_duty_reg <= buck_duty_reg - 8'd1;
                                end
                            end
                            else if ({4'd0, cfg_reg.buck_target_mv} < sat_q)
                            begin
                                if (buck_duty_reg != 8'hFF)
                                begin
                                    buck_duty_reg <= buck_duty_reg + 8'd1;
                                end
                            end
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_FINISH:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
            // buck shut off before its conversion starts
            if (state_reg == S_BCK_MUL && !wait_reg && buck_off)
            begin
                buck_duty_reg <= 8'hFF;
                state_reg     <= S_FINISH;
                wait_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_FINISH)
        begin
            out_reg.boost_duty        <= boost_duty_reg;
            out_reg.buck_duty         <= buck_duty_reg;
            out_reg.boost_measured_mv <= boost_level_reg;
            out_reg.buck_measured_mv  <= buck_level_reg;
            out_reg.supply_mv         <= supply_reg;
            out_reg.boost_shutdown    <= boost_off;
            out_reg.buck_shutdown     <= buck_off;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = out_reg;
    assign pready    = 1'b1;

    always_comb
    begin
        case (cfg_idx)
            dcpr_pkg::REG_BOOST_TARGET: prdata = {16'd0, cfg_reg.boost_target_mv};
            dcpr_pkg::REG_BOOST_MAX:    prdata = {24'd0, cfg_reg.boost_duty_max};
            dcpr_pkg::REG_BOOST_TOP:    prdata = {12'd0, cfg_reg.boost_r_top};
            dcpr_pkg::REG_BOOST_BOT:    prdata = {12'd0, cfg_reg.boost_r_bottom};
            dcpr_pkg::REG_BUCK_TARGET:  prdata = {16'd0, cfg_reg.buck_target_mv};
            dcpr_pkg::REG_BUCK_TOP:     prdata = {12'd0, cfg_reg.buck_r_top};
            dcpr_pkg::REG_BUCK_BOT:     prdata = {12'd0, cfg_reg.buck_r_bottom};
            default:                    prdata = {16'd0, cfg_reg.supply_refresh_interval};
        endcase
    end
endmodule

/* src/dcpr_checker.sv */
// ----------------------------------------------------------------------------
// dcpr_checker
// Port-level checks of the regulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "dual_converter_pwm_regulator_assert.svh"
module dcpr_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input dcpr_pkg::out_item_t out_data
);
    `DCPR_ASSERT(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled item changed")
    `DCPR_ASSERT(a_busy_out, clk, rst_n, out_valid |-> in_stall, "input taken while item waits")
    `DCPR_ASSERT(a_one_out, clk, rst_n, out_valid && !out_stall |=> !out_valid, "item repeated")
    `DCPR_ASSERT(a_boost_off, clk, rst_n, out_valid && out_data.boost_shutdown |-> out_data.boost_duty == 8'd0, "boost not off")
    `DCPR_ASSERT_NR(a_reset, clk, rst_n && $past(!rst_n) |-> !out_valid, "output valid after reset")
endmodule

bind dual_converter_pwm_regulator dcpr_checker u_dcpr_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual converter PWM regulator: a local model of
// the duty stepping, level conversion and supply refresh predicts every result
// item, which is compared field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
    localparam int HOLD_CYCLES = 800;
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int DRAIN_CYCLES = 600;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    dcpr_pkg::in_item_t  in_data = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    dcpr_pkg::out_item_t out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [4:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    dual_converter_pwm_regulator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #10 clk = ~clk;

    // regulator model state and register copy
    dcpr_pkg::cfg_t regs;
    logic [15:0]    est_tick;
    logic [20:0]    est_supply;
    logic [7:0]     est_boost_duty;
    logic [7:0]     est_buck_duty;
    logic [19:0]    est_boost_level;
    logic [19:0]    est_buck_level;

    dcpr_pkg::out_item_t pending_results[$];
    int          errors = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          reg_writes = 0;
    int          idle_cycles = 0;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    function automatic logic [19:0] convert_mv(logic [9:0] sample, logic [19:0] top,
                                               logic [19:0] bottom);
        longint unsigned mv;
        mv = (longint'(sample) * longint'(est_supply)) / 1023;
        if (top != 0 && bottom != 0)
            mv = (mv * (longint'(top) + longint'(bottom))) / longint'(bottom);
        if (mv > 64'hFFFFF)
            mv = 64'hFFFFF;
        return mv[19:0];
    endfunction

    task automatic regulate_tick(input dcpr_pkg::in_item_t it,
                                 output dcpr_pkg::out_item_t r);
        logic boost_off;
        logic buck_off;
        int   d;
        boost_off = 1'b0;
        buck_off = 1'b0;
        est_tick = est_tick + 16'd1;
        if (est_tick >= regs.supply_refresh_interval)
        begin
            if (it.reference_sample != 0)
                est_supply = 21'(1125300 / int'(it.reference_sample));
            est_tick = '0;
        end
        if (regs.boost_target_mv > 20000 || !it.power_on)
        begin
            est_boost_duty = '0;
            boost_off = 1'b1;
        end
        else
        begin
            est_boost_level = convert_mv(it.boost_sample, regs.boost_r_top, regs.boost_r_bottom);
            if (regs.boost_target_mv > est_boost_level)
            begin
                d = int'(est_boost_duty) + 1;
                est_boost_duty = (d > regs.boost_duty_max) ? regs.boost_duty_max : 8'(d);
            end
            else if (regs.boost_target_mv < est_boost_level)
            begin
                d = (est_boost_duty == 0) ? 0 : int'(est_boost_duty) - 1;
                est_boost_duty = (d > regs.boost_duty_max) ? regs.boost_duty_max : 8'(d);
            end
        end
        if (regs.buck_target_mv < 1500 || !it.power_on)
        begin
            est_buck_duty = 8'd255;
            buck_off = 1'b1;
        end
        else
        begin
            est_buck_level = convert_mv(it.buck_sample, regs.buck_r_top, regs.buck_r_bottom);
            if (regs.buck_target_mv > est_buck_level)
            begin
                if (est_buck_duty > 0)
                    est_buck_duty = est_buck_duty - 8'd1;
            end
            else if (regs.buck_target_mv < est_buck_level)
            begin
                if (est_buck_duty < 255)
                    est_buck_duty = est_buck_duty + 8'd1;
            end
        end
        r.boost_duty = est_boost_duty;
        r.buck_duty = est_buck_duty;
        r.boost_measured_mv = est_boost_level;
        r.buck_measured_mv = est_buck_level;
        r.supply_mv = est_supply;
        r.boost_shutdown = boost_off;
        r.buck_shutdown = buck_off;
    endtask

    function automatic void check_field(string name, longint unsigned exp_v,
                                        longint unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        dcpr_pkg::out_item_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result item with no prediction waiting");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("boost_duty", e.boost_duty, out_data.boost_duty);
                check_field("buck_duty", e.buck_duty, out_data.buck_duty);
                check_field("boost_measured_mv", e.boost_measured_mv,
                            out_data.boost_measured_mv);
                check_field("buck_measured_mv", e.buck_measured_mv,
                            out_data.buck_measured_mv);
                check_field("supply_mv", e.supply_mv, out_data.supply_mv);
                check_field("boost_shutdown", e.boost_shutdown, out_data.boost_shutdown);
                check_field("buck_shutdown", e.buck_shutdown, out_data.buck_shutdown);
            end
        end
    end

    // receiver: random stall bursts, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_item(input dcpr_pkg::in_item_t it);
        dcpr_pkg::out_item_t r;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        regulate_tick(it, r);
        pending_results.push_back(r);
        items_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            dcpr_pkg::REG_BOOST_TARGET: regs.boost_target_mv = value[15:0];
            dcpr_pkg::REG_BOOST_MAX:    regs.boost_duty_max = value[7:0];
            dcpr_pkg::REG_BOOST_TOP:    regs.boost_r_top = value[19:0];
            dcpr_pkg::REG_BOOST_BOT:    regs.boost_r_bottom = value[19:0];
            dcpr_pkg::REG_BUCK_TARGET:  regs.buck_target_mv = value[15:0];
            dcpr_pkg::REG_BUCK_TOP:     regs.buck_r_top = value[19:0];
            dcpr_pkg::REG_BUCK_BOT:     regs.buck_r_bottom = value[19:0];
            default:                    regs.supply_refresh_interval = value[15:0];
        endcase
        reg_writes++;
    endtask

    function automatic dcpr_pkg::in_item_t make_item(logic [9:0] bs, logic [9:0] ks,
                                                     logic [9:0] rs, logic pw);
        dcpr_pkg::in_item_t it;
        it.boost_sample = bs;
        it.buck_sample = ks;
        it.reference_sample = rs;
        it.power_on = pw;
        return it;
    endfunction

    function automatic dcpr_pkg::in_item_t random_item();
        return make_item(10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                         ($urandom_range(0, 15) == 0) ? 10'd0 : 10'($urandom_range(1, 1023)),
                         $urandom_range(0, 9) != 0);
    endfunction

    task automatic test_reset_defaults();
        send_item(make_item(10'd0, 10'd0, 10'd0, 1'b1));
        send_item(make_item(10'd1023, 10'd1023, 10'd1023, 1'b1));
        send_item(make_item(10'd512, 10'd300, 10'd1, 1'b0));
        send_item(make_item(10'd100, 10'd600, 10'd225, 1'b1));
    endtask

    task automatic test_supply_refresh();
        write_reg(dcpr_pkg::REG_INTERVAL, 32'd0);
        send_item(make_item(10'd700, 10'd400, 10'd1, 1'b1));
        send_item(make_item(10'd700, 10'd400, 10'd0, 1'b1));
        send_item(make_item(10'd1023, 10'd1023, 10'd1023, 1'b1));
        write_reg(dcpr_pkg::REG_INTERVAL, 32'd2);
        repeat (4) send_item(make_item(10'd800, 10'd200, 10'd250, 1'b1));
    endtask

    task automatic test_limits_and_dividers();
        write_reg(dcpr_pkg::REG_BOOST_TARGET, 32'd20001);
        write_reg(dcpr_pkg::REG_BUCK_TARGET, 32'd1499);
        send_item(make_item(10'd500, 10'd500, 10'd230, 1'b1));
        write_reg(dcpr_pkg::REG_BOOST_TARGET, 32'd20000);
        write_reg(dcpr_pkg::REG_BUCK_TARGET, 32'd1500);
        send_item(make_item(10'd500, 10'd500, 10'd230, 1'b1));
        write_reg(dcpr_pkg::REG_BOOST_TOP, 32'hFFFFF);
        write_reg(dcpr_pkg::REG_BOOST_BOT, 32'd1);
        write_reg(dcpr_pkg::REG_BUCK_TOP, 32'd1000);
        write_reg(dcpr_pkg::REG_BUCK_BOT, 32'hFFFFF);
        send_item(make_item(10'd1023, 10'd1023, 10'd1, 1'b1));
        send_item(make_item(10'd0, 10'd1023, 10'd1, 1'b1));
        write_reg(dcpr_pkg::REG_BOOST_MAX, 32'd0);
        send_item(make_item(10'd0, 10'd0, 10'd1, 1'b1));
        write_reg(dcpr_pkg::REG_BOOST_MAX, 32'd255);
        write_reg(dcpr_pkg::REG_BOOST_TARGET, 32'd65535);
        write_reg(dcpr_pkg::REG_BUCK_TARGET, 32'd65535);
        send_item(make_item(10'd0, 10'd0, 10'd1, 1'b0));
        send_item(make_item(10'd0, 10'd0, 10'd1, 1'b1));
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (12) send_item(random_item());
    endtask

    task automatic randomise_regs(input int mode);
        write_reg(dcpr_pkg::REG_BOOST_TARGET,
                  (mode == 0) ? 32'd0 : $urandom_range(0, 22000));
        write_reg(dcpr_pkg::REG_BOOST_MAX,
                  (mode == 1) ? 32'd255 : $urandom_range(0, 255));
        write_reg(dcpr_pkg::REG_BOOST_TOP,
                  (mode == 2) ? 32'd0 : $urandom_range(0, 20'hFFFFF));
        write_reg(dcpr_pkg::REG_BOOST_BOT,
                  $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 50000));
        write_reg(dcpr_pkg::REG_BUCK_TARGET,
                  (mode == 3) ? 32'd0 : $urandom_range(1200, 6000));
        write_reg(dcpr_pkg::REG_BUCK_TOP,
                  $urandom_range(0, 2) == 0 ? 32'd0 : $urandom_range(0, 20000));
        write_reg(dcpr_pkg::REG_BUCK_BOT,
                  (mode == 4) ? 32'hFFFFF : $urandom_range(0, 20000));
        write_reg(dcpr_pkg::REG_INTERVAL,
                  (mode == 5) ? 32'd65535 : $urandom_range(0, 12));
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 8; phase++)
        begin
            randomise_regs(phase);
            if (phase == 7)
                quiet = 1'b1;
            repeat (95) send_item(random_item());
        end
    endtask

    initial
    begin
        regs = '{16'd10000, 8'd200, 20'd10000, 20'd3300, 16'd2500, 20'd0, 20'd0, 16'd10000};
        est_tick = '0;
        est_supply = 21'd5000;
        est_boost_duty = '0;
        est_buck_duty = 8'd255;
        est_boost_level = '0;
        est_buck_level = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_supply_refresh();
        test_limits_and_dividers();
        test_backpressure();
        test_random();
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d predicted results never arrived", pending_results.size());
            errors++;
        end
        $display("Sent %0d items, checked %0d results, %0d register writes,",
                 items_sent, results_seen, reg_writes);
        $display("covering shutdown limits, divider extremes, refresh and back-pressure.");
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
